### src/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Types and constants shared by the page frame allocator modules: field
// widths, function and status codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package pfa_pkg;

  // Field widths of the request, result and configuration ports.
  localparam int FUNC_W       = 3;
  localparam int COUNT_W      = 11;
  localparam int SLOT_W       = 10;
  localparam int ADDR_W       = 32;
  localparam int STATUS_W     = 2;
  localparam int PAGE_COUNT_W = 11;
  localparam int FRAME_W      = 20;
  localparam int CFG_DATA_W   = 20;
  localparam int CFG_INDEX_W  = 1;
  localparam int PAGE_SHIFT   = 12;

  // The occupancy map is stored as words of page flags.
  localparam int WORD_W  = 32;
  localparam int WORD_BW = 5;
  // Bit position inside a word, with room for the value WORD_W itself.
  localparam int REL_W   = 6;

  // Request function codes.
  localparam logic [FUNC_W-1:0] FUNC_INIT      = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC_ONE = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC_RUN = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_FREE      = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_MARK      = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BADARG  = 2'd2;

  // Configuration register indexes and their reset values.
  localparam logic [CFG_INDEX_W-1:0]  CFG_PAGE_COUNT  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0]  CFG_FIRST_FRAME = 1'd1;
  localparam logic [PAGE_COUNT_W-1:0] PAGE_COUNT_RST  = 11'd1024;
  localparam logic [FRAME_W-1:0]      FIRST_FRAME_RST = 20'd0;

  // Datapath load operations.
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_CLEAR     = 3'd0;
  localparam logic [OP_W-1:0] OP_INIT      = 3'd1;
  localparam logic [OP_W-1:0] OP_ALLOC_ONE = 3'd2;
  localparam logic [OP_W-1:0] OP_ALLOC_RUN = 3'd3;
  localparam logic [OP_W-1:0] OP_FREE      = 3'd4;
  localparam logic [OP_W-1:0] OP_MARK      = 3'd5;

  // How a sweep rewrites each map word.
  localparam int MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_FILL  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SET   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                load;
    logic [OP_W-1:0]     op;
    logic                step;
    logic                scan;
    logic                mark;
    logic                sweep;
    logic                emit;
    logic                emit_addr;
    logic [STATUS_W-1:0] status;
  } pfa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_gt_n;
    logic count_zero;
    logic slot_ge_n;
    logic n_zero;
    logic hit;
    logic at_last;
  } pfa_stat_t;

endpackage

### src/page_frame_allocator_unit.sv
// ----------------------------------------------------------------------------
// page_frame_allocator_unit
// First-fit page frame allocator over a one-bit-per-page occupancy map held
// in a RAM of 32-bit words. A request is taken when start is high and busy is
// low; its result appears on out_address and out_status for exactly one cycle
// with out_valid high, and the receiver cannot stall it. Rejected requests
// answer in the cycle after they are taken. Allocations read the map one
// word per cycle through the single RAM read port: an allocation reads the
// words from the first one up to the word in which its run ends, then
// rewrites every word the run covers; a failing search reads every word
// that holds managed pages. Free and mark used rewrite one word, and
// initialise rewrites every map word. After reset the block clears the
// map, one word per cycle, and holds busy high until that pass ends;
// configuration writes may be made whenever no request is in flight,
// including during that pass.
// ----------------------------------------------------------------------------
module page_frame_allocator_unit #(
  parameter int MAX_PAGES = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [pfa_pkg::FUNC_W-1:0]        in_func,
  input  logic [pfa_pkg::COUNT_W-1:0]       in_count,
  input  logic [pfa_pkg::SLOT_W-1:0]        in_page_slot,
  output logic                              out_valid,
  output logic [pfa_pkg::ADDR_W-1:0]        out_address,
  output logic [pfa_pkg::STATUS_W-1:0]      out_status,
  input  logic                              cfg_we,
  input  logic [pfa_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pfa_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pfa_pkg::*;

  pfa_cmd_t  cmd;
  pfa_stat_t stat;

  // Request sequencing.
  pfa_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_func),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  // Map storage, search and result formation.
  pfa_dpath #(
    .MAX_PAGES (MAX_PAGES)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_count     (in_count),
    .in_page_slot (in_page_slot),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_address  (out_address),
    .out_status   (out_status)
  );

endmodule

### src/pfa_ram.sv
// ----------------------------------------------------------------------------
// pfa_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module pfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/pfa_dpath.sv
// ----------------------------------------------------------------------------
// pfa_dpath
// Allocator datapath: configuration registers, occupancy map memory, the
// word-wide first-fit run search and the read-modify-write sweep unit.
// ----------------------------------------------------------------------------
module pfa_dpath #(
  parameter int MAX_PAGES = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [pfa_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [pfa_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [pfa_pkg::COUNT_W-1:0]         in_count,
  input  logic [pfa_pkg::SLOT_W-1:0]          in_page_slot,
  input  pfa_pkg::pfa_cmd_t                   cmd,
  output pfa_pkg::pfa_stat_t                  stat,
  output logic                                out_valid,
  output logic [pfa_pkg::ADDR_W-1:0]          out_address,
  output logic [pfa_pkg::STATUS_W-1:0]        out_status
);
  import pfa_pkg::*;

  // Page counts must hold both the count field and MAX_PAGES itself.
  localparam int CNT_W = ($clog2(MAX_PAGES + 1) > COUNT_W) ? $clog2(MAX_PAGES + 1) : COUNT_W;
  localparam int DEPTH = (MAX_PAGES + WORD_W - 1) / WORD_W;
  localparam int WAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WIX_W = CNT_W - WORD_BW;

  logic [PAGE_COUNT_W-1:0] page_count_r;
  logic [FRAME_W-1:0]      first_frame_r;
  logic [MODE_W-1:0]       mode_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [CNT_W-1:0]        lo_r;
  logic [CNT_W-1:0]        hi_r;
  logic [CNT_W-1:0]        run_r;
  logic [WAW-1:0]          rd_w_r;
  logic [WAW-1:0]          cur_w_r;
  logic [WAW-1:0]          last_w_r;
  logic [WORD_BW-1:0]      hit_b_r;
  logic                    has_addr_r;
  logic                    out_valid_r;
  logic [ADDR_W-1:0]       out_address_r;
  logic [STATUS_W-1:0]     out_status_r;

  logic [CNT_W-1:0]        n_pages;
  logic [CNT_W-1:0]        count_ext;
  logic [CNT_W-1:0]        slot_ext;
  logic [WORD_W-1:0]       ram_rdata;
  logic [WORD_W-1:0]       ram_wdata;
  logic [WORD_W-1:0]       managed;
  logic [WORD_W-1:0]       used;
  logic [WORD_W-1:0]       wmask;
  logic [WORD_W-1:0]       hit_vec;
  logic [REL_W-1:0]        lu [WORD_BW+1][WORD_W];
  logic [CNT_W-1:0]        len [WORD_W];
  logic [WORD_BW-1:0]      hit_b;
  logic [CNT_W-1:0]        mark_hi;
  logic [CNT_W-1:0]        mark_lo;
  logic [FRAME_W-1:0]      frame_sum;

  // Mask of the bits of word w whose page index lies in [lo, hi).
  function automatic logic [WORD_W-1:0] range_mask(input logic [WAW-1:0] w,
                                                   input logic [CNT_W-1:0] lo,
                                                   input logic [CNT_W-1:0] hi);
    logic [WIX_W-1:0]  wx;
    logic [WIX_W-1:0]  lo_w;
    logic [WIX_W-1:0]  hi_w;
    logic [REL_W-1:0]  lo_rel;
    logic [REL_W-1:0]  hi_rel;
    logic [WORD_W-1:0] m;
    wx   = WIX_W'(w);
    lo_w = lo[CNT_W-1:WORD_BW];
    hi_w = hi[CNT_W-1:WORD_BW];
    if (lo_w < wx) begin
      lo_rel = '0;
    end else if (lo_w == wx) begin
      lo_rel = REL_W'(lo[WORD_BW-1:0]);
    end else begin
      lo_rel = REL_W'(WORD_W);
    end
    if (hi_w < wx) begin
      hi_rel = '0;
    end else if (hi_w == wx) begin
      hi_rel = REL_W'(hi[WORD_BW-1:0]);
    end else begin
      hi_rel = REL_W'(WORD_W);
    end
    for (int b = 0; b < WORD_W; b++) begin
      m[b] = (REL_W'(b) >= lo_rel) && (REL_W'(b) < hi_rel);
    end
    return m;
  endfunction

  // Effective number of managed pages and widened request fields.
  assign n_pages   = (CNT_W'(page_count_r) > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES)
                                                                 : CNT_W'(page_count_r);
  assign count_ext = CNT_W'(in_count);
  assign slot_ext  = CNT_W'(in_page_slot);

  // Status toward the controller.
  assign stat.count_gt_n = count_ext > n_pages;
  assign stat.count_zero = count_ext == '0;
  assign stat.slot_ge_n  = slot_ext >= n_pages;
  assign stat.n_zero     = n_pages == '0;
  assign stat.hit        = |hit_vec;
  assign stat.at_last    = cur_w_r == last_w_r;

  // Run search over one map word. Pages beyond the managed range count as
  // used. A prefix scan finds, for each bit, the nearest used page at or
  // below it; from that follows the length of the free run ending there.
  assign managed = range_mask(cur_w_r, CNT_W'(0), n_pages);
  assign used    = ram_rdata | ~managed;

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      lu[0][b] = used[b] ? REL_W'(b + 1) : '0;
    end
    for (int l = 0; l < WORD_BW; l++) begin
      for (int b = 0; b < WORD_W; b++) begin
        if (b >= (1 << l)) begin
          lu[l+1][b] = (lu[l][b] != '0) ? lu[l][b] : lu[l][b - (1 << l)];
        end else begin
          lu[l+1][b] = lu[l][b];
        end
      end
    end
    for (int b = 0; b < WORD_W; b++) begin
      if (lu[WORD_BW][b] == '0) begin
        len[b] = run_r + CNT_W'(b + 1);
      end else begin
        len[b] = CNT_W'(b + 1) - CNT_W'(lu[WORD_BW][b]);
      end
      hit_vec[b] = len[b] >= cnt_r;
    end
    hit_b = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (hit_vec[b]) begin
        hit_b = WORD_BW'(b);
      end
    end
  end

  // Range of the run that was found: it ends just after the hit bit.
  assign mark_hi = CNT_W'({cur_w_r, hit_b_r}) + CNT_W'(1);
  assign mark_lo = mark_hi - cnt_r;

  // New contents of the word being swept.
  assign wmask = range_mask(cur_w_r, lo_r, hi_r);

  always_comb begin
    case (mode_r)
      MODE_FILL:  ram_wdata = wmask;
      MODE_SET:   ram_wdata = ram_rdata | wmask;
      MODE_CLEAR: ram_wdata = ram_rdata & ~wmask;
      default:    ram_wdata = ram_rdata;
    endcase
  end

  // Frame number of the allocated page, wrapping at the frame width.
  assign frame_sum = first_frame_r + FRAME_W'(lo_r);

  // Occupancy map: one bit per page, one word per entry.
  pfa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (cmd.sweep),
    .waddr (cur_w_r),
    .wdata (ram_wdata),
    .raddr (rd_w_r),
    .rdata (ram_rdata)
  );

  // Configuration registers and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_count_r  <= PAGE_COUNT_RST;
      first_frame_r <= FIRST_FRAME_RST;
      out_valid_r   <= 1'b0;
      has_addr_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PAGE_COUNT:  page_count_r  <= PAGE_COUNT_W'(cfg_data);
          CFG_FIRST_FRAME: first_frame_r <= cfg_data;
          default: ;
        endcase
      end
      out_valid_r <= cmd.emit;
      if (cmd.load) begin
        has_addr_r <= 1'b0;
      end else if (cmd.mark) begin
        has_addr_r <= 1'b1;
      end
    end
  end

  // Sweep, scan and result registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      case (cmd.op)
        OP_CLEAR: begin
          mode_r   <= MODE_FILL;
          lo_r     <= '0;
          hi_r     <= '0;
          rd_w_r   <= '0;
          last_w_r <= WAW'(DEPTH - 1);
        end
        OP_INIT: begin
          mode_r   <= MODE_FILL;
          lo_r     <= '0;
          hi_r     <= count_ext;
          rd_w_r   <= '0;
          last_w_r <= WAW'(DEPTH - 1);
        end
        OP_ALLOC_ONE, OP_ALLOC_RUN: begin
          cnt_r    <= (cmd.op == OP_ALLOC_ONE) ? CNT_W'(1) : count_ext;
          run_r    <= '0;
          rd_w_r   <= '0;
          last_w_r <= WAW'((n_pages - CNT_W'(1)) >> WORD_BW);
        end
        OP_FREE, OP_MARK: begin
          mode_r   <= (cmd.op == OP_MARK) ? MODE_SET : MODE_CLEAR;
          lo_r     <= slot_ext;
          hi_r     <= slot_ext + CNT_W'(1);
          rd_w_r   <= WAW'(slot_ext >> WORD_BW);
          last_w_r <= WAW'(slot_ext >> WORD_BW);
        end
        default: ;
      endcase
    end else if (cmd.mark) begin
      mode_r   <= MODE_SET;
      lo_r     <= mark_lo;
      hi_r     <= mark_hi;
      rd_w_r   <= WAW'(mark_lo >> WORD_BW);
      last_w_r <= cur_w_r;
    end else if (cmd.step) begin
      cur_w_r <= rd_w_r;
      rd_w_r  <= rd_w_r + WAW'(1);
    end
    if (cmd.scan) begin
      run_r   <= len[WORD_W-1];
      hit_b_r <= hit_b;
    end
    if (cmd.emit) begin
      out_status_r  <= cmd.status;
      out_address_r <= (cmd.emit_addr && has_addr_r)
                       ? ADDR_W'({frame_sum, {PAGE_SHIFT{1'b0}}}) : '0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_address = out_address_r;
  assign out_status  = out_status_r;

  // A found run lies wholly inside the map, below its end.
  a_mark_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mark |=> (lo_r < hi_r) && (hi_r <= n_pages))
    else $error("allocated run range is malformed");

  // A sweep never writes past the last word of its range.
  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sweep |-> (cur_w_r <= last_w_r))
    else $error("sweep wrote past its last word");

  // Every result carries one of the defined status codes.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r <= STATUS_BADARG))
    else $error("result status code undefined");

endmodule

### src/pfa_ctrl.sv
// ----------------------------------------------------------------------------
// pfa_ctrl
// Allocator controller: decodes requests, checks arguments and sequences the
// map scan, the run marking and the map sweeps.
// ----------------------------------------------------------------------------
module pfa_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pfa_pkg::FUNC_W-1:0]    in_func,
  input  pfa_pkg::pfa_stat_t            stat,
  output pfa_pkg::pfa_cmd_t             cmd,
  output logic                          busy
);
  import pfa_pkg::*;

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] S_RESET       = 3'd0;
  localparam logic [ST_W-1:0] S_IDLE        = 3'd1;
  localparam logic [ST_W-1:0] S_SCAN_PRIME  = 3'd2;
  localparam logic [ST_W-1:0] S_SCAN        = 3'd3;
  localparam logic [ST_W-1:0] S_MARK        = 3'd4;
  localparam logic [ST_W-1:0] S_SWEEP_PRIME = 3'd5;
  localparam logic [ST_W-1:0] S_SWEEP       = 3'd6;

  logic [ST_W-1:0] state_r;
  logic [ST_W-1:0] state_nxt;
  // Set while the map clearing after reset runs: it gives no result.
  logic            quiet_r;
  logic            quiet_nxt;

  // Next state and datapath commands.
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    quiet_nxt = quiet_r;
    case (state_r)
      S_RESET: begin
        cmd.load  = 1'b1;
        cmd.op    = OP_CLEAR;
        quiet_nxt = 1'b1;
        state_nxt = S_SWEEP_PRIME;
      end
      S_IDLE: begin
        if (start) begin
          quiet_nxt = 1'b0;
          case (in_func)
            FUNC_INIT: begin
              if (stat.count_gt_n) begin
                cmd.emit   = 1'b1;
                cmd.status = STATUS_BADARG;
              end else begin
                cmd.load  = 1'b1;
                cmd.op    = OP_INIT;
                state_nxt = S_SWEEP_PRIME;
              end
            end
            FUNC_ALLOC_ONE: begin
              if (stat.n_zero) begin
                cmd.emit   = 1'b1;
                cmd.status = STATUS_NOSPACE;
              end else begin
                cmd.load  = 1'b1;
                cmd.op    = OP_ALLOC_ONE;
                state_nxt = S_SCAN_PRIME;
              end
            end
            FUNC_ALLOC_RUN: begin
              if (stat.count_zero || stat.count_gt_n) begin
                cmd.emit   = 1'b1;
                cmd.status = STATUS_BADARG;
              end else begin
                cmd.load  = 1'b1;
                cmd.op    = OP_ALLOC_RUN;
                state_nxt = S_SCAN_PRIME;
              end
            end
            FUNC_FREE, FUNC_MARK: begin
              if (stat.slot_ge_n) begin
                cmd.emit   = 1'b1;
                cmd.status = STATUS_BADARG;
              end else begin
                cmd.load  = 1'b1;
                cmd.op    = (in_func == FUNC_MARK) ? OP_MARK : OP_FREE;
                state_nxt = S_SWEEP_PRIME;
              end
            end
            default: begin
              cmd.emit   = 1'b1;
              cmd.status = STATUS_BADARG;
            end
          endcase
        end
      end
      S_SCAN_PRIME: begin
        cmd.step  = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.hit) begin
          state_nxt = S_MARK;
        end else if (stat.at_last) begin
          cmd.emit   = 1'b1;
          cmd.status = STATUS_NOSPACE;
          state_nxt  = S_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_MARK: begin
        cmd.mark  = 1'b1;
        state_nxt = S_SWEEP_PRIME;
      end
      S_SWEEP_PRIME: begin
        cmd.step  = 1'b1;
        state_nxt = S_SWEEP;
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.at_last) begin
          cmd.emit      = !quiet_r;
          cmd.emit_addr = 1'b1;
          cmd.status    = STATUS_DONE;
          state_nxt     = S_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RESET;
      quiet_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      quiet_r <= quiet_nxt;
    end
  end

  assign busy = state_r != S_IDLE;

  // Every result ends the request: the controller is idle afterwards.
  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (state_r == S_IDLE))
    else $error("controller not idle after a result");

  // The clearing pass after reset gives no result.
  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP && quiet_r) |-> !cmd.emit)
    else $error("result produced by the reset clearing pass");

  // A datapath load is always followed by a read priming cycle.
  a_load_prime: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_SCAN_PRIME || state_r == S_SWEEP_PRIME))
    else $error("load not followed by a priming cycle");

endmodule

### tb/tb_page_frame_allocator_unit.sv
// ----------------------------------------------------------------------------
// tb_page_frame_allocator_unit
// Self-checking bench for the page frame allocator. A tracker keeps its own
// occupancy map and register copies, predicts the address and status of
// every accepted request, and matches each result strobe against the oldest
// prediction. Stimulus is a directed opening followed by random phases, each
// with its own page count and first frame, and random idle cycles.
// ----------------------------------------------------------------------------
module tb_page_frame_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import pfa_pkg::*;

  localparam int MAP_DEPTH      = 1024;
  localparam int QUIET_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 64;
  localparam int REPORT_LIMIT   = 10;
  localparam int ITEMS_PER_PASS = 65;
  localparam logic [FRAME_W-1:0] TOP_FRAME = '1;

  // One allocator answer: address and status.
  typedef struct packed {
    logic [ADDR_W-1:0]   address;
    logic [STATUS_W-1:0] status;
  } grant_t;

  // Tracks the page map and predicts the answer to each request.
  class alloc_tracker;
    bit                      page_used [MAP_DEPTH];
    logic [PAGE_COUNT_W-1:0] page_count;
    logic [FRAME_W-1:0]      first_frame;
    grant_t                  pending_grants [$];
    int                      errors;

    function new();
      foreach (page_used[i]) page_used[i] = 1'b0;
      page_count  = PAGE_COUNT_RST;
      first_frame = FIRST_FRAME_RST;
      errors      = 0;
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      if (index == CFG_PAGE_COUNT) begin
        page_count = data[PAGE_COUNT_W-1:0];
      end else if (index == CFG_FIRST_FRAME) begin
        first_frame = data[FRAME_W-1:0];
      end
    endfunction

    // Pages actually managed; larger counts saturate at the map depth.
    function int managed();
      return (page_count > MAP_DEPTH) ? MAP_DEPTH : int'(page_count);
    endfunction

    function logic [ADDR_W-1:0] frame_address(int slot);
      logic [ADDR_W-1:0] frame;
      frame = ADDR_W'(first_frame) + ADDR_W'(slot);
      return frame << PAGE_SHIFT;
    endfunction

    function int pending();
      return pending_grants.size();
    endfunction

    // Apply one accepted request to the map and queue its expected answer.
    function void take_request(logic [FUNC_W-1:0] func, logic [COUNT_W-1:0] count,
                               logic [SLOT_W-1:0] slot);
      int     n;
      int     run;
      int     first;
      bit     found;
      grant_t grant;
      n             = managed();
      run           = 0;
      first         = 0;
      found         = 1'b0;
      grant.address = '0;
      grant.status  = STATUS_DONE;
      case (func)
        FUNC_INIT: begin
          if (int'(count) > n) begin
            grant.status = STATUS_BADARG;
          end else begin
            foreach (page_used[i]) page_used[i] = (i < int'(count));
          end
        end
        FUNC_ALLOC_ONE: begin
          for (int i = 0; i < n && !found; i++) begin
            if (!page_used[i]) begin
              found = 1'b1;
              first = i;
            end
          end
          if (found) begin
            page_used[first] = 1'b1;
            grant.address    = frame_address(first);
          end else begin
            grant.status = STATUS_NOSPACE;
          end
        end
        FUNC_ALLOC_RUN: begin
          if (count == 0 || int'(count) > n) begin
            grant.status = STATUS_BADARG;
          end else begin
            // First fit: stop at the first place where the run reaches count.
            for (int i = 0; i < n && !found; i++) begin
              if (page_used[i]) begin
                run = 0;
              end else begin
                run++;
                if (run == int'(count)) begin
                  found = 1'b1;
                  first = i + 1 - int'(count);
                end
              end
            end
            if (found) begin
              for (int i = 0; i < int'(count); i++) page_used[first + i] = 1'b1;
              grant.address = frame_address(first);
            end else begin
              grant.status = STATUS_NOSPACE;
            end
          end
        end
        FUNC_FREE, FUNC_MARK: begin
          if (int'(slot) >= n) begin
            grant.status = STATUS_BADARG;
          end else begin
            page_used[slot] = (func == FUNC_MARK);
          end
        end
        default: begin
          grant.status = STATUS_BADARG;
        end
      endcase
      pending_grants.push_back(grant);
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    // Compare one result with the oldest expected answer.
    function void match_grant(logic [ADDR_W-1:0] address, logic [STATUS_W-1:0] status);
      grant_t want;
      if (pending_grants.size() == 0) begin
        report($sformatf("ERROR: result with nothing pending: address %h status %0d",
                         address, status));
      end else begin
        want = pending_grants.pop_front();
        if (address !== want.address) begin
          report($sformatf("ERROR: address expected %h, got %h", want.address, address));
        end
        if (status !== want.status) begin
          report($sformatf("ERROR: status expected %0d, got %0d", want.status, status));
        end
      end
    endfunction
  endclass

  logic                    clk          = 1'b0;
  logic                    rst_n        = 1'b0;
  logic                    start        = 1'b0;
  logic                    busy;
  logic [FUNC_W-1:0]       in_func      = FUNC_INIT;
  logic [COUNT_W-1:0]      in_count     = '0;
  logic [SLOT_W-1:0]       in_page_slot = '0;
  logic                    out_valid;
  logic [ADDR_W-1:0]       out_address;
  logic [STATUS_W-1:0]     out_status;
  logic                    cfg_we       = 1'b0;
  logic [CFG_INDEX_W-1:0]  cfg_index    = CFG_PAGE_COUNT;
  logic [CFG_DATA_W-1:0]   cfg_data     = '0;

  alloc_tracker tracker;
  bit           calm  = 1'b0;
  int           quiet = 0;

  page_frame_allocator_unit #(
    .MAX_PAGES(MAP_DEPTH)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_func     (in_func),
    .in_count    (in_count),
    .in_page_slot(in_page_slot),
    .out_valid   (out_valid),
    .out_address (out_address),
    .out_status  (out_status),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check every result strobe.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) tracker.match_grant(out_address, out_status);
  end

  // Watchdog: end the run after a long stretch with no request or result.
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Issue one request, with random idle cycles first unless in a calm stretch.
  task automatic send_request(input logic [FUNC_W-1:0] func, input logic [COUNT_W-1:0] count,
                              input logic [SLOT_W-1:0] slot);
    while (!calm && $urandom_range(0, 99) < 34) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    in_func      <= func;
    in_count     <= count;
    in_page_slot <= slot;
    do @(posedge clk); while (busy !== 1'b0);
    tracker.take_request(func, count, slot);
  endtask

  // Stop issuing and wait until every answer is back and the block is idle.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0 || busy !== 1'b0);
  endtask

  // One register write; the write enable is low again when the task returns.
  task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_register(index, data);
    @(posedge clk);
  endtask

  function automatic logic [SLOT_W-1:0] pick_slot(int n);
    if (n == 0 || $urandom_range(0, 9) == 0) return SLOT_W'($urandom());
    return SLOT_W'($urandom_range(0, n - 1));
  endfunction

  function automatic logic [COUNT_W-1:0] pick_run(int n);
    case ($urandom_range(0, 9))
      7:       return (n > 0) ? COUNT_W'($urandom_range(1, n)) : '0;
      8:       return ($urandom_range(0, 1) == 0) ? '0 : COUNT_W'(n + 1);
      9:       return COUNT_W'($urandom());
      default: return COUNT_W'($urandom_range(1, 8));
    endcase
  endfunction

  // One random phase: new registers, an initialise, then a request mix.
  task automatic run_pass(input logic [PAGE_COUNT_W-1:0] pages,
                          input logic [FRAME_W-1:0] frame, input int items);
    int                 n;
    int                 pick;
    logic [FUNC_W-1:0]  func;
    logic [COUNT_W-1:0] count;
    logic [SLOT_W-1:0]  slot;
    drain();
    write_register(CFG_PAGE_COUNT, CFG_DATA_W'(pages));
    write_register(CFG_FIRST_FRAME, frame);
    n = tracker.managed();
    send_request(FUNC_INIT, COUNT_W'($urandom_range(0, n)), SLOT_W'($urandom()));
    repeat (items) begin
      pick  = $urandom_range(0, 99);
      count = COUNT_W'($urandom());
      slot  = SLOT_W'($urandom());
      if (pick < 28) begin
        func = FUNC_ALLOC_ONE;
      end else if (pick < 50) begin
        func  = FUNC_ALLOC_RUN;
        count = pick_run(n);
      end else if (pick < 72) begin
        func = FUNC_FREE;
        slot = pick_slot(n);
      end else if (pick < 86) begin
        func = FUNC_MARK;
        slot = pick_slot(n);
      end else if (pick < 90) begin
        func = FUNC_INIT;
        if ($urandom_range(0, 3) != 0) count = COUNT_W'($urandom_range(0, n));
      end else begin
        // Function codes past mark used are unassigned.
        func = FUNC_W'($urandom_range(int'(FUNC_MARK) + 1, (1 << FUNC_W) - 1));
      end
      send_request(func, count, slot);
    end
  endtask

  initial begin
    logic [PAGE_COUNT_W-1:0] pass_pages [12];
    logic [FRAME_W-1:0]      frame;
    tracker    = new();
    pass_pages = '{11'd1024, 11'd1, 11'd2047, 11'd33, 11'd2, 11'd0,
                   11'd1023, 11'd64, 11'd0, 11'd0, 11'd32, 11'd1024};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);

    // Directed opening on the reset registers: full map of 1024 pages.
    send_request(FUNC_ALLOC_ONE, '0, '0);
    send_request(FUNC_ALLOC_RUN, '0, '0);
    send_request(FUNC_ALLOC_RUN, 11'd1025, '0);
    send_request(FUNC_ALLOC_RUN, '1, '1);
    send_request(FUNC_INIT, '1, '0);
    send_request(FUNC_INIT, 11'd1024, '0);
    send_request(FUNC_ALLOC_ONE, '0, '0);
    send_request(FUNC_ALLOC_RUN, 11'd1, '0);
    send_request(FUNC_FREE, '0, '1);
    send_request(FUNC_FREE, '0, 10'd1022);
    send_request(FUNC_ALLOC_RUN, 11'd2, '0);
    send_request(FUNC_W'(int'(FUNC_MARK) + 1), '0, '0);
    send_request(FUNC_INIT, '0, '0);
    send_request(FUNC_MARK, '0, 10'd5);
    send_request(FUNC_ALLOC_RUN, 11'd8, '0);
    send_request(FUNC_ALLOC_RUN, 11'd1024, '0);
    send_request(FUNC_INIT, '0, '0);
    send_request(FUNC_ALLOC_RUN, 11'd1024, '0);

    // No managed pages, top frame number.
    drain();
    write_register(CFG_PAGE_COUNT, '0);
    write_register(CFG_FIRST_FRAME, TOP_FRAME);
    send_request(FUNC_ALLOC_ONE, '0, '0);
    send_request(FUNC_ALLOC_RUN, 11'd1, '0);
    send_request(FUNC_FREE, '0, '0);
    send_request(FUNC_MARK, '0, '0);
    send_request(FUNC_INIT, '0, '0);

    // Three pages at the top frame: the second address wraps.
    drain();
    write_register(CFG_PAGE_COUNT, 20'd3);
    send_request(FUNC_MARK, '0, 10'd3);
    send_request(FUNC_ALLOC_ONE, '0, '0);
    send_request(FUNC_ALLOC_ONE, '0, '0);

    // Random phases; two of them run with no idle cycles at all.
    pass_pages[8] = PAGE_COUNT_W'($urandom_range(1, MAP_DEPTH));
    pass_pages[9] = PAGE_COUNT_W'($urandom_range(1, 128));
    for (int p = 0; p < 12; p++) begin
      case (p % 4)
        0:       frame = FRAME_W'($urandom());
        1:       frame = TOP_FRAME;
        2:       frame = '0;
        default: frame = TOP_FRAME - FRAME_W'($urandom_range(0, 63));
      endcase
      calm = (p == 3 || p == 4);
      run_pass(pass_pages[p], frame, (pass_pages[p] == 0) ? 20 : ITEMS_PER_PASS);
    end
    calm = 1'b0;

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
